/* hdl/fat12_cluster_chain_step_core_macros.svh */
// ----------------------------------------------------------------------------
// FAT12 cluster chain step: assertion macros
// Shared concurrent checks, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_STEP_CORE_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_STEP_CORE_MACROS_SVH

// same-cycle implication
`define FCC_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCC_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain step: package
// Field widths, request and response types, register codes and constants.
// ----------------------------------------------------------------------------
package fcc_pkg;

   localparam int CLUSTER_W  = 12;
   localparam int FAT_ADDR_W = 13;
   localparam int BYTE_W     = 8;
   localparam int SECTOR_W   = 16;
   localparam int ENTRY_W    = 12;
   localparam int NIBBLE_W   = 4;

   // highest entry start offset reachable by a cluster number
   localparam int OFF_MAX = ((2 ** CLUSTER_W - 1) * 3) / 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam int DIR_ENTRY_LOG2 = 5;

   localparam logic [ENTRY_W-1:0] ENTRY_LAST_LINK = 12'hff0;

   localparam logic [15:0] RESERVED_RESET = 16'd1;
   localparam logic [3:0]  FAT_COUNT_RESET = 4'd2;
   localparam logic [15:0] SPF_RESET = 16'd9;
   localparam logic [15:0] ROOT_RESET = 16'd224;
   localparam logic [3:0]  SHIFT_RESET = 4'd9;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_LOOKUP = 1'b1
   } fcc_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RESERVED  = 3'd0,
      REG_FAT_COUNT = 3'd1,
      REG_SPF       = 3'd2,
      REG_ROOT      = 3'd3,
      REG_SHIFT     = 3'd4
   } fcc_reg_type;

   typedef struct packed {
      logic                  req_type;
      logic [FAT_ADDR_W-1:0] fat_addr;
      logic [BYTE_W-1:0]     fat_byte;
      logic [CLUSTER_W-1:0]  cluster;
   } fcc_req_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector_index;
      logic [ENTRY_W-1:0]  next_cluster;
      logic                chain_end;
   } fcc_rsp_type;

   // request as it travels down the pipeline
   typedef struct packed {
      logic                 lookup;
      logic                 wr_hit;
      logic [BYTE_W-1:0]    fat_byte;
      logic [CLUSTER_W-1:0] cluster;
   } fcc_slot_type;

endpackage

/* hdl/fcc_csr.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain step: configuration registers
// APB register file and the precomputed first data sector base.
// ----------------------------------------------------------------------------
module fcc_csr
   import fcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [SECTOR_W-1:0]   base_sector
);

   logic [15:0] reserved_ff, reserved_in;
   logic [3:0]  fat_count_ff, fat_count_in;
   logic [15:0] spf_ff, spf_in;
   logic [15:0] root_ff, root_in;
   logic [3:0]  shift_ff, shift_in;
   logic [SECTOR_W-1:0] base_ff, base_in;

   logic                 wr_en;
   logic [CSR_IDX_W-1:0] idx;
   logic [19:0]          fat_sectors;
   logic [20:0]          root_bytes;
   logic [20:0]          root_sectors;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      reserved_in  = reserved_ff;
      fat_count_in = fat_count_ff;
      spf_in       = spf_ff;
      root_in      = root_ff;
      shift_in     = shift_ff;
      if (wr_en) begin
         unique case (idx)
            REG_RESERVED:  reserved_in  = pwdata[15:0];
            REG_FAT_COUNT: fat_count_in = pwdata[3:0];
            REG_SPF:       spf_in       = pwdata[15:0];
            REG_ROOT:      root_in      = pwdata[15:0];
            REG_SHIFT:     shift_in     = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_RESERVED:  prdata = CSR_DATA_W'(reserved_ff);
         REG_FAT_COUNT: prdata = CSR_DATA_W'(fat_count_ff);
         REG_SPF:       prdata = CSR_DATA_W'(spf_ff);
         REG_ROOT:      prdata = CSR_DATA_W'(root_ff);
         REG_SHIFT:     prdata = CSR_DATA_W'(shift_ff);
         default:       prdata = '0;
      endcase
   end

   // reserved + FAT sectors + root directory sectors - 2, wrapping at 16 bits
   always_comb begin
      fat_sectors  = 20'(fat_count_ff) * 20'(spf_ff);
      root_bytes   = {root_ff, {DIR_ENTRY_LOG2{1'b0}}};
      root_sectors = root_bytes >> shift_ff;
      base_in      = reserved_ff + fat_sectors[SECTOR_W-1:0]
                     + root_sectors[SECTOR_W-1:0] - SECTOR_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff  <= RESERVED_RESET;
         fat_count_ff <= FAT_COUNT_RESET;
         spf_ff       <= SPF_RESET;
         root_ff      <= ROOT_RESET;
         shift_ff     <= SHIFT_RESET;
      end else begin
         reserved_ff  <= reserved_in;
         fat_count_ff <= fat_count_in;
         spf_ff       <= spf_in;
         root_ff      <= root_in;
         shift_ff     <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   assign base_sector = base_ff;

endmodule

/* hdl/fcc_addr.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain step: address generation
// Entry offset cluster*3/2, reduced modulo the store size over two stages.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_step_core_macros.svh"

module fcc_addr
   import fcc_pkg::*;
#(
   parameter  int FAT_BYTES = 8192,
   localparam int ADDR_W    = $clog2(FAT_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fcc_req_type       req_data,
   output logic              s2_valid,
   output fcc_slot_type      s2_slot,
   output logic [ADDR_W-1:0] s2_addr0,
   output logic [ADDR_W-1:0] s2_addr1,
   input  logic              s2_ready
);

   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = RECIP_SHIFT - $clog2(FAT_BYTES) + 1;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / FAT_BYTES;
   localparam int QMAX   = OFF_MAX / FAT_BYTES;
   localparam int Q_W    = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
   localparam int PROD_W = (FAT_ADDR_W + RECIP_W > RECIP_SHIFT + Q_W) ?
                           FAT_ADDR_W + RECIP_W : RECIP_SHIFT + Q_W;
   localparam int SPAN_W = ((ADDR_W + 1 > FAT_ADDR_W) ? ADDR_W + 1 : FAT_ADDR_W) + 1;

   logic                  s1_valid_ff, s1_valid_in;
   fcc_slot_type          s1_slot_ff, s1_slot_in;
   logic [FAT_ADDR_W-1:0] s1_off_ff, s1_off_in;
   logic [Q_W-1:0]        s1_q_ff, s1_q_in;

   logic                  s2_valid_ff, s2_valid_in;
   fcc_slot_type          s2_slot_ff, s2_slot_in;
   logic [ADDR_W-1:0]     s2_addr0_ff, s2_addr0_in;
   logic [ADDR_W-1:0]     s2_addr1_ff, s2_addr1_in;

   logic                  s1_room, s2_room;
   logic                  is_lookup;
   logic [FAT_ADDR_W:0]   tri_w;
   logic [PROD_W-1:0]     prod;
   logic [SPAN_W-1:0]     span_raw, span_fix;

   assign s2_room   = !s2_valid_ff || s2_ready;
   assign s1_room   = !s1_valid_ff || s2_room;
   assign req_ready = s1_room;

   // stage 1: entry offset and quotient estimate by reciprocal
   always_comb begin
      is_lookup = (req_data.req_type == REQ_LOOKUP);
      tri_w     = (FAT_ADDR_W + 1)'({req_data.cluster, 1'b0})
                  + (FAT_ADDR_W + 1)'(req_data.cluster);
      prod      = PROD_W'(tri_w[FAT_ADDR_W:1]) * PROD_W'(RECIP);

      s1_slot_in.lookup   = is_lookup;
      s1_slot_in.wr_hit   = !is_lookup
                            && (SPAN_W'(req_data.fat_addr) < SPAN_W'(FAT_BYTES));
      s1_slot_in.fat_byte = req_data.fat_byte;
      s1_slot_in.cluster  = req_data.cluster;
      s1_off_in           = is_lookup ? tri_w[FAT_ADDR_W:1] : req_data.fat_addr;
      s1_q_in             = is_lookup ? prod[RECIP_SHIFT +: Q_W] : '0;
      s1_valid_in         = s1_room ? req_valid : s1_valid_ff;
   end

   // stage 2: remainder with one correction, then the following byte
   always_comb begin
      span_raw    = SPAN_W'(s1_off_ff) - SPAN_W'(s1_q_ff) * SPAN_W'(FAT_BYTES);
      span_fix    = (span_raw >= SPAN_W'(FAT_BYTES)) ?
                    span_raw - SPAN_W'(FAT_BYTES) : span_raw;
      s2_addr0_in = span_fix[ADDR_W-1:0];
      s2_addr1_in = (span_fix == SPAN_W'(FAT_BYTES - 1)) ?
                    '0 : ADDR_W'(span_fix + SPAN_W'(1));
      s2_slot_in  = s1_slot_ff;
      s2_valid_in = s2_room ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_room) begin
         s1_slot_ff <= s1_slot_in;
         s1_off_ff  <= s1_off_in;
         s1_q_ff    <= s1_q_in;
      end
      if (s2_room) begin
         s2_slot_ff  <= s2_slot_in;
         s2_addr0_ff <= s2_addr0_in;
         s2_addr1_ff <= s2_addr1_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_slot  = s2_slot_ff;
   assign s2_addr0 = s2_addr0_ff;
   assign s2_addr1 = s2_addr1_ff;

   `FCC_CHECK(addr_pair_adjacent, clock, reset, s2_valid_ff && s2_slot_ff.lookup, (SPAN_W'(s2_addr1_ff) == SPAN_W'(s2_addr0_ff) + SPAN_W'(1)) || ((s2_addr1_ff == '0) && (SPAN_W'(s2_addr0_ff) == SPAN_W'(FAT_BYTES - 1))), "entry byte addresses not adjacent")
   `FCC_CHECK_NEXT(addr_hold_on_stall, clock, reset, s2_valid_ff && !s2_ready, s2_valid_ff && $stable(s2_addr0_ff) && $stable(s2_addr1_ff), "stalled addresses changed")

endmodule

/* hdl/fcc_store.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain step: FAT byte store
// One write port for loads, two read ports fetch both bytes of an entry.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_step_core_macros.svh"

module fcc_store
   import fcc_pkg::*;
#(
   parameter  int FAT_BYTES = 8192,
   localparam int ADDR_W    = $clog2(FAT_BYTES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s2_valid,
   input  fcc_slot_type         s2_slot,
   input  logic [ADDR_W-1:0]    s2_addr0,
   input  logic [ADDR_W-1:0]    s2_addr1,
   output logic                 s2_ready,
   output logic                 s3_valid,
   output logic [CLUSTER_W-1:0] s3_cluster,
   output logic [BYTE_W-1:0]    s3_byte0,
   output logic [BYTE_W-1:0]    s3_byte1,
   input  logic                 s3_ready
);

   logic [BYTE_W-1:0] fat_mem [FAT_BYTES];

   logic                 s3_valid_ff, s3_valid_in;
   logic [CLUSTER_W-1:0] s3_cluster_ff;
   logic [BYTE_W-1:0]    rd0_ff, rd1_ff;
   logic                 s3_room, take;

   assign s3_room     = !s3_valid_ff || s3_ready;
   assign take        = s2_valid && s3_room;
   assign s2_ready    = s3_room;
   assign s3_valid_in = s3_room ? (s2_valid && s2_slot.lookup) : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (take && s2_slot.wr_hit) begin
         fat_mem[s2_addr0] <= s2_slot.fat_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (take && s2_slot.lookup) begin
         rd0_ff        <= fat_mem[s2_addr0];
         rd1_ff        <= fat_mem[s2_addr1];
         s3_cluster_ff <= s2_slot.cluster;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   assign s3_valid   = s3_valid_ff;
   assign s3_cluster = s3_cluster_ff;
   assign s3_byte0   = rd0_ff;
   assign s3_byte1   = rd1_ff;

   `FCC_CHECK_NEXT(store_hold_on_stall, clock, reset, s3_valid_ff && !s3_ready, s3_valid_ff && $stable(rd0_ff) && $stable(rd1_ff) && $stable(s3_cluster_ff), "stalled read data changed")

endmodule

/* hdl/fat12_cluster_chain_step_core.sv */
// ----------------------------------------------------------------------------
// FAT12 cluster chain step core
// Holds a FAT12 table and resolves one cluster lookup per request.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries load and lookup requests. A load writes one FAT byte
//   at fat_addr (ignored beyond the store) and returns nothing. A lookup
//   returns one rsp: data sector, 12-bit next cluster and chain end flag.
//   Configuration registers sit on the APB port at byte addresses 4*i;
//   write them only while no request is in flight.
//   Pipeline: a lookup passes the offset and quotient, remainder, store read
//   and output registers, in that order, before it shows on rsp.
//   Throughput: one request per cycle unless rsp is stalled, set by the two
//   read ports of the byte store that deliver both entry bytes in one access.
//   Stall: when rsp_ready is low the result holds in the output register;
//   the pipeline stages keep filling behind it and req_ready drops only
//   once every stage holds a request.
//   Reset: clears the pipeline and restores register defaults; the FAT
//   store is not cleared, so only bytes written by loads may be looked up.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_step_core_macros.svh"

module fat12_cluster_chain_step_core
   import fcc_pkg::*;
#(
   parameter int FAT_BYTES = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fcc_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fcc_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = $clog2(FAT_BYTES);

   logic [SECTOR_W-1:0]  base_sector;
   logic                 s2_valid, s2_ready;
   fcc_slot_type         s2_slot;
   logic [ADDR_W-1:0]    s2_addr0, s2_addr1;
   logic                 s3_valid, s3_ready;
   logic [CLUSTER_W-1:0] s3_cluster;
   logic [BYTE_W-1:0]    s3_byte0, s3_byte1;

   logic                 rsp_valid_ff, rsp_valid_in;
   fcc_rsp_type          rsp_data_ff, rsp_data_in;
   logic [ENTRY_W-1:0]   entry;

   fcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .base_sector (base_sector)
   );

   fcc_addr #(.FAT_BYTES(FAT_BYTES)) u_addr (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .s2_valid  (s2_valid),
      .s2_slot   (s2_slot),
      .s2_addr0  (s2_addr0),
      .s2_addr1  (s2_addr1),
      .s2_ready  (s2_ready)
   );

   fcc_store #(.FAT_BYTES(FAT_BYTES)) u_store (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2_slot    (s2_slot),
      .s2_addr0   (s2_addr0),
      .s2_addr1   (s2_addr1),
      .s2_ready   (s2_ready),
      .s3_valid   (s3_valid),
      .s3_cluster (s3_cluster),
      .s3_byte0   (s3_byte0),
      .s3_byte1   (s3_byte1),
      .s3_ready   (s3_ready)
   );

   assign s3_ready = !rsp_valid_ff || rsp_ready;

   // odd cluster: high nibble of first byte below the second byte
   // even cluster: first byte below the low nibble of the second byte
   always_comb begin
      if (s3_cluster[0]) begin
         entry = {s3_byte1, s3_byte0[BYTE_W-1:NIBBLE_W]};
      end else begin
         entry = {s3_byte1[NIBBLE_W-1:0], s3_byte0};
      end
      rsp_data_in.sector_index = base_sector + SECTOR_W'(s3_cluster);
      rsp_data_in.next_cluster = entry;
      rsp_data_in.chain_end    = (entry == '0) || (entry > ENTRY_LAST_LINK);
      rsp_valid_in             = s3_ready ? s3_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid && s3_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FCC_CHECK_NEXT(rsp_only_from_lookup, clock, reset, s3_ready && !s3_valid, !rsp_valid_ff, "response without a lookup")

endmodule
